FILE: src/incremental_pi_pressure_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the incremental PI pressure controller
// Short forms for clocked implications with a synchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_PI_PRESSURE_CONTROLLER_UNIT_ASSERT_SVH
`define INCREMENTAL_PI_PRESSURE_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define IPPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IPPC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/ippc_pkg.sv
// ----------------------------------------------------------------------------
// ippc_pkg
// Types and constants shared by the pressure controller modules.
// ----------------------------------------------------------------------------
package ippc_pkg;

   localparam int GAIN_W   = 20;
   localparam int DBAND_W  = 8;
   localparam int LIMIT_W  = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;
   localparam int TARGET_W = 11;
   localparam int CMD_W    = 16;
   localparam int DRIVE_W  = 13;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_NOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PREV = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_BAND = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LOW   = 3'd4;

   // item kinds
   localparam logic REQ_SETPOINT = 1'b0;
   localparam logic REQ_SAMPLE   = 1'b1;

   // reset values
   localparam logic [GAIN_W-1:0]   GAIN_NOW_RST  = 20'd254677;
   localparam logic [GAIN_W-1:0]   GAIN_PREV_RST = 20'd79656;
   localparam logic [DBAND_W-1:0]  DEAD_BAND_RST = 8'd5;
   localparam logic [LIMIT_W-1:0]  OUT_HIGH_RST  = 31'd629145600;
   localparam logic [LIMIT_W-1:0]  OUT_LOW_RST   = 31'd262144000;
   localparam logic [TARGET_W-1:0] TARGET_RST    = 11'd620;

   // set-point mapping
   localparam logic [CMD_W-1:0]    SETPOINT_MAX  = 16'd100;
   localparam logic [TARGET_W-1:0] TARGET_BASE   = 11'd620;
   localparam logic [DRIVE_W-1:0]  DRIVE_MAX     = 13'd8191;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_now;
      logic [GAIN_W-1:0]  gain_prev;
      logic [DBAND_W-1:0] dead_band;
      logic [LIMIT_W-1:0] out_high;
      logic [LIMIT_W-1:0] out_low;
   } cfg_type;

endpackage

FILE: src/ippc_csr.sv
// ----------------------------------------------------------------------------
// ippc_csr
// Configuration register file: write-only, one register per index.
// ----------------------------------------------------------------------------
module ippc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ippc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ippc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output ippc_pkg::cfg_type                  cfg
);

   ippc_pkg::cfg_type cfg_ff;
   ippc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ippc_pkg::CSR_GAIN_NOW:  cfg_in.gain_now  = csr_wdata[ippc_pkg::GAIN_W-1:0];
            ippc_pkg::CSR_GAIN_PREV: cfg_in.gain_prev = csr_wdata[ippc_pkg::GAIN_W-1:0];
            ippc_pkg::CSR_DEAD_BAND: cfg_in.dead_band = csr_wdata[ippc_pkg::DBAND_W-1:0];
            ippc_pkg::CSR_OUT_HIGH:  cfg_in.out_high  = csr_wdata[ippc_pkg::LIMIT_W-1:0];
            ippc_pkg::CSR_OUT_LOW:   cfg_in.out_low   = csr_wdata[ippc_pkg::LIMIT_W-1:0];
            default:                 cfg_in = cfg_ff;   // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_now  <= ippc_pkg::GAIN_NOW_RST;
         cfg_ff.gain_prev <= ippc_pkg::GAIN_PREV_RST;
         cfg_ff.dead_band <= ippc_pkg::DEAD_BAND_RST;
         cfg_ff.out_high  <= ippc_pkg::OUT_HIGH_RST;
         cfg_ff.out_low   <= ippc_pkg::OUT_LOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/ippc_step.sv
// ----------------------------------------------------------------------------
// ippc_step
// One controller update: set-point mapping, error, dead band, PI sum, clamp, drive scaling.
// ----------------------------------------------------------------------------
module ippc_step #(
   parameter int SAMPLE_BITS = 12,
   parameter int OUT_SHIFT   = 18,
   parameter int ERR_W       = 13
) (
   input  ippc_pkg::cfg_type                  cfg,
   input  logic [ippc_pkg::CMD_W-1:0]         cmd,
   input  logic [SAMPLE_BITS-1:0]             sample,
   input  logic [ippc_pkg::TARGET_W-1:0]      target,
   input  logic signed [ERR_W-1:0]            last_error,
   input  logic [ippc_pkg::LIMIT_W-1:0]       last_output,
   output logic [ippc_pkg::TARGET_W-1:0]      target_next,
   output logic signed [ERR_W-1:0]            error_next,
   output logic [ippc_pkg::LIMIT_W-1:0]       output_next,
   output logic [ippc_pkg::DRIVE_W-1:0]       drive
);

   localparam int PROD_W = ippc_pkg::GAIN_W + 1 + ERR_W;
   localparam int SUM_W  = PROD_W + 2;

   logic [6:0]                         cmd_ok;
   logic signed [ERR_W-1:0]            err;
   logic [ERR_W-1:0]                   mag;
   logic                               hold;
   logic signed [ippc_pkg::GAIN_W:0]   g_now;
   logic signed [ippc_pkg::GAIN_W:0]   g_prev;
   logic signed [PROD_W-1:0]           p_now;
   logic signed [PROD_W-1:0]           p_prev;
   logic signed [SUM_W-1:0]            u_raw;
   logic signed [SUM_W-1:0]            u_sel;
   logic signed [SUM_W-1:0]            lim_hi;
   logic signed [SUM_W-1:0]            lim_lo;
   logic [ippc_pkg::LIMIT_W-1:0]       shifted;

   // set-point: out-of-range commands map to zero
   assign cmd_ok = (cmd > ippc_pkg::SETPOINT_MAX) ? 7'd0 : cmd[6:0];
   assign target_next = ippc_pkg::TARGET_W'(cmd_ok) * 11'd3 + ippc_pkg::TARGET_BASE;

   assign err  = $signed(ERR_W'(target)) - $signed(ERR_W'(sample));
   assign mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
   assign hold = mag < ERR_W'(cfg.dead_band);

   assign g_now  = $signed({1'b0, cfg.gain_now});
   assign g_prev = $signed({1'b0, cfg.gain_prev});
   assign p_now  = g_now * err;
   assign p_prev = g_prev * last_error;

   assign u_raw = $signed(SUM_W'(last_output)) + SUM_W'(p_now) - SUM_W'(p_prev);
   assign u_sel = hold ? $signed(SUM_W'(last_output)) : u_raw;

   assign lim_hi = $signed(SUM_W'(cfg.out_high));
   assign lim_lo = $signed(SUM_W'(cfg.out_low));

   // upper limit is tested first when the limits cross
   always_comb begin
      if (u_sel > lim_hi) begin
         output_next = cfg.out_high;
      end else if (u_sel < lim_lo) begin
         output_next = cfg.out_low;
      end else begin
         output_next = u_sel[ippc_pkg::LIMIT_W-1:0];
      end
   end

   assign error_next = hold ? '0 : err;

   assign shifted = output_next >> OUT_SHIFT;
   assign drive = (shifted > ippc_pkg::LIMIT_W'(ippc_pkg::DRIVE_MAX)) ?
                  ippc_pkg::DRIVE_MAX : shifted[ippc_pkg::DRIVE_W-1:0];

endmodule

FILE: src/incremental_pi_pressure_controller_unit.sv
// ----------------------------------------------------------------------------
// incremental_pi_pressure_controller_unit
// Velocity-form PI pressure controller with set-point commands and dead band.
// ----------------------------------------------------------------------------
// A pressure sample passes the input stage and then the result register.
// Throughput: one item per cycle while the result side does not stall;
//   the PI update in ippc_step is combinational, so samples run back to back.
// Set-point commands occupy only the input stage and give no result.
// Reset (synchronous, active high) restores the registers and the controller
//   state to their defaults and empties both stages.
// ----------------------------------------------------------------------------
module incremental_pi_pressure_controller_unit #(
   parameter int OUT_SHIFT   = 18,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [7:0]                          req_cmd_high,
   input  logic [7:0]                          req_cmd_low,
   input  logic [SAMPLE_BITS-1:0]              req_pressure,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ippc_pkg::DRIVE_W-1:0]        rsp_drive,
   // configuration port
   input  logic                                csr_we,
   input  logic [ippc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ippc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // error must hold target (up to 11 bits) minus a full-scale sample
   localparam int ERR_W = ((SAMPLE_BITS > ippc_pkg::TARGET_W) ?
                           SAMPLE_BITS : ippc_pkg::TARGET_W) + 1;

   ippc_pkg::cfg_type cfg;

   // input stage
   logic                             s1_valid_ff;
   logic                             s1_valid_in;
   logic                             s1_type_ff;
   logic [ippc_pkg::CMD_W-1:0]       s1_cmd_ff;
   logic [SAMPLE_BITS-1:0]           s1_sample_ff;

   // controller state
   logic [ippc_pkg::TARGET_W-1:0]    target_ff;
   logic [ippc_pkg::TARGET_W-1:0]    target_in;
   logic signed [ERR_W-1:0]          last_error_ff;
   logic signed [ERR_W-1:0]          last_error_in;
   logic [ippc_pkg::LIMIT_W-1:0]     last_output_ff;
   logic [ippc_pkg::LIMIT_W-1:0]     last_output_in;

   // result stage
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [ippc_pkg::DRIVE_W-1:0]     rsp_drive_ff;
   logic [ippc_pkg::DRIVE_W-1:0]     drive_in;

   logic                             req_take;
   logic                             out_free;
   logic                             s1_is_sample;
   logic                             s1_move;
   logic                             rsp_take;

   ippc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ippc_step #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .OUT_SHIFT   (OUT_SHIFT),
      .ERR_W       (ERR_W)
   ) u_step (
      .cfg         (cfg),
      .cmd         (s1_cmd_ff),
      .sample      (s1_sample_ff),
      .target      (target_ff),
      .last_error  (last_error_ff),
      .last_output (last_output_ff),
      .target_next (target_in),
      .error_next  (last_error_in),
      .output_next (last_output_in),
      .drive       (drive_in)
   );

   // Handshake. The result register is free when empty or being taken.
   // A command in the input stage always retires; a sample retires only
   // into a free result register. Accept a new item whenever the input
   // stage is empty or retiring this cycle.
   assign rsp_take     = rsp_valid_ff && !rsp_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_is_sample = (s1_type_ff == ippc_pkg::REQ_SAMPLE);
   assign s1_move      = s1_valid_ff && (!s1_is_sample || out_free);
   assign req_stall    = s1_valid_ff && !s1_move;
   assign req_take     = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = (s1_move && s1_is_sample) || (rsp_valid_ff && !rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the input stage on accept, otherwise hold
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_type_ff   <= req_type;
         s1_cmd_ff    <= {req_cmd_high, req_cmd_low};
         s1_sample_ff <= req_pressure;
      end
   end

   // Advance the controller state as the item retires: a command writes the
   // target, a sample writes the stored error and output.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff      <= ippc_pkg::TARGET_RST;
         last_error_ff  <= '0;
         last_output_ff <= '0;
      end else if (s1_move) begin
         if (s1_is_sample) begin
            last_error_ff  <= last_error_in;
            last_output_ff <= last_output_in;
         end else begin
            target_ff <= target_in;
         end
      end
   end

   // capture the drive value alongside its valid
   always_ff @(posedge clock) begin
      if (s1_move && s1_is_sample) begin
         rsp_drive_ff <= drive_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule

FILE: src/ippc_checker.sv
// ----------------------------------------------------------------------------
// ippc_checker
// Port-level checks of the pressure controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "incremental_pi_pressure_controller_unit_assert.svh"

module ippc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_type,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [ippc_pkg::DRIVE_W-1:0]    rsp_drive
);

   logic sample_take;

   assign sample_take = req_valid && !req_stall && (req_type == ippc_pkg::REQ_SAMPLE);

   // a stalled result holds
   `IPPC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_drive), "stalled result changed")

   // input backs up only behind a stalled result
   `IPPC_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stall without stalled result")

   // no result appears without a sample taken just before
   `IPPC_ASSERT_NXT(a_no_spurious, clock, reset, !rsp_valid && !$past(sample_take), !rsp_valid, "result without sample")

   // a sample taken passes from the input stage into the result register once it is free
   `IPPC_ASSERT_NXT(a_sample_out, clock, reset, $past(!reset) && $past(sample_take) && (!rsp_valid || !rsp_stall), rsp_valid, "sample lost")

endmodule

bind incremental_pi_pressure_controller_unit ippc_checker u_ippc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_type  (req_type),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_drive (rsp_drive)
);

FILE: verif/incremental_pi_pressure_controller_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// incremental_pi_pressure_controller_unit_tb
// Self-checking bench for the velocity-form PI pressure controller. A directed
// table covers the set-point mapping, the dead band edges and the output
// clamps. Random phases then run under several register settings, including
// extreme and crossed limits. Typed rows check a fixed drive value; every other
// drive result is checked against an in-bench copy of the controller state,
// with random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module incremental_pi_pressure_controller_unit_tb;

   localparam int OUT_SHIFT   = 18;
   localparam int SAMPLE_BITS = 12;

   localparam int IDLE_PCT         = 37;
   localparam int ITEMS_PER_PHASE  = 220;
   localparam int PHASE_COUNT      = 8;
   localparam int HOLD_CYCLES      = 300;
   localparam int SETTLE_CYCLES    = 8;
   localparam int GAIN_MAX         = (1 << ippc_pkg::GAIN_W) - 1;
   localparam logic [ippc_pkg::LIMIT_W-1:0] LIMIT_MAX = {ippc_pkg::LIMIT_W{1'b1}};
   localparam int TIMEOUT_NS       = 3_000_000;

   // first register index past the end of the map
   localparam logic [ippc_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd5;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_type;
   logic [7:0]                      req_cmd_high;
   logic [7:0]                      req_cmd_low;
   logic [SAMPLE_BITS-1:0]          req_pressure;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [ippc_pkg::DRIVE_W-1:0]    rsp_drive;
   logic                            csr_we;
   logic [ippc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ippc_pkg::CSR_DATA_W-1:0] csr_wdata;

   incremental_pi_pressure_controller_unit #(
      .OUT_SHIFT   (OUT_SHIFT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_cmd_high (req_cmd_high),
      .req_cmd_low  (req_cmd_low),
      .req_pressure (req_pressure),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_drive    (rsp_drive),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Controller copy: registers and loop state as the block should hold them
   // ------------------------------------------------------------------------
   logic [ippc_pkg::GAIN_W-1:0]    cfg_gain_now;
   logic [ippc_pkg::GAIN_W-1:0]    cfg_gain_prev;
   logic [ippc_pkg::DBAND_W-1:0]   cfg_dead_band;
   logic [ippc_pkg::LIMIT_W-1:0]   cfg_out_high;
   logic [ippc_pkg::LIMIT_W-1:0]   cfg_out_low;
   logic [ippc_pkg::TARGET_W-1:0]  ctl_target;
   logic signed [12:0]             ctl_last_error;
   logic [31:0]                    ctl_last_output;

   logic [ippc_pkg::DRIVE_W-1:0]   expected_drive[$];
   int                             mismatch_count;

   // shared between the sender and the result-side stall process
   bit                             quiet;
   bit                             hold_go;

   typedef struct {
      logic                         kind;
      logic [7:0]                   cmd_high;
      logic [7:0]                   cmd_low;
      logic [SAMPLE_BITS-1:0]       pressure;
      bit                           typed;
      logic [ippc_pkg::DRIVE_W-1:0] drive;
   } stim_row_type;

   localparam int DIRECTED_N = 24;
   stim_row_type directed_rows [DIRECTED_N];

   // ------------------------------------------------------------------------
   // Clock and run limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Reporting
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   // ------------------------------------------------------------------------
   // Register write into the controller copy; bits above a field's width drop
   // ------------------------------------------------------------------------
   task automatic apply_reg(input logic [ippc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ippc_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         ippc_pkg::CSR_GAIN_NOW:  cfg_gain_now  = data[ippc_pkg::GAIN_W-1:0];
         ippc_pkg::CSR_GAIN_PREV: cfg_gain_prev = data[ippc_pkg::GAIN_W-1:0];
         ippc_pkg::CSR_DEAD_BAND: cfg_dead_band = data[ippc_pkg::DBAND_W-1:0];
         ippc_pkg::CSR_OUT_HIGH:  cfg_out_high  = data[ippc_pkg::LIMIT_W-1:0];
         ippc_pkg::CSR_OUT_LOW:   cfg_out_low   = data[ippc_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Advance the controller copy by one item; a sample yields one drive value
   // ------------------------------------------------------------------------
   task automatic predict_drive(input logic kind, input logic [7:0] hi,
                                input logic [7:0] lo,
                                input logic [SAMPLE_BITS-1:0] pres,
                                output bit has_result,
                                output logic [ippc_pkg::DRIVE_W-1:0] drive);
      logic [ippc_pkg::CMD_W-1:0] cmd;
      longint                     err;
      longint                     mag;
      longint                     u;
      longint                     last_l;
      logic [31:0]                shifted;
      has_result = 1'b0;
      drive      = '0;
      if (kind == ippc_pkg::REQ_SETPOINT) begin
         // out-of-range commands fall back to the base target
         cmd = {hi, lo};
         if (cmd > ippc_pkg::SETPOINT_MAX)
            cmd = '0;
         ctl_target = ippc_pkg::TARGET_W'(3 * cmd + ippc_pkg::TARGET_BASE);
      end else begin
         err    = longint'(ctl_target) - longint'(pres);
         mag    = (err < 0) ? -err : err;
         last_l = longint'(ctl_last_output);
         if (mag < longint'(cfg_dead_band)) begin
            // inside the dead band: hold the output, forget the error
            u   = last_l;
            err = 0;
         end else begin
            u = last_l + longint'(cfg_gain_now) * err
                - longint'(cfg_gain_prev) * longint'(ctl_last_error);
         end
         // upper test wins when the limits cross
         if (u > longint'(cfg_out_high))
            u = longint'(cfg_out_high);
         else if (u < longint'(cfg_out_low))
            u = longint'(cfg_out_low);
         ctl_last_output = u[31:0];
         ctl_last_error  = err[12:0];
         shifted = ctl_last_output >> OUT_SHIFT;
         drive   = (shifted > ippc_pkg::DRIVE_MAX) ? ippc_pkg::DRIVE_MAX :
                   shifted[ippc_pkg::DRIVE_W-1:0];
         has_result = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Input channel: offer one item, idle at random first, hold until taken
   // ------------------------------------------------------------------------
   task automatic send_item(input logic kind, input logic [7:0] hi,
                            input logic [7:0] lo,
                            input logic [SAMPLE_BITS-1:0] pres,
                            input bit typed,
                            input logic [ippc_pkg::DRIVE_W-1:0] typed_drive);
      bit                           has_result;
      logic [ippc_pkg::DRIVE_W-1:0] drive;
      @(negedge clock);
      if (!quiet) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            // idle cycle: drop valid, scramble the payload
            req_valid    <= 1'b0;
            req_type     <= 1'($urandom);
            req_cmd_high <= 8'($urandom);
            req_cmd_low  <= 8'($urandom);
            req_pressure <= SAMPLE_BITS'($urandom);
            @(negedge clock);
         end
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_cmd_high <= hi;
      req_cmd_low  <= lo;
      req_pressure <= pres;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_drive(kind, hi, lo, pres, has_result, drive);
      if (has_result)
         expected_drive.push_back(typed ? typed_drive : drive);
   endtask

   // Random item: mostly legal set-points and samples near the target so the
   // dead band edges get hit, the rest raw commands and full-range samples.
   task automatic random_item();
      int                         pick;
      int                         offset;
      logic [ippc_pkg::CMD_W-1:0] cmd;
      logic [SAMPLE_BITS-1:0]     pres;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         cmd = ippc_pkg::CMD_W'($urandom_range(0, ippc_pkg::SETPOINT_MAX));
         send_item(ippc_pkg::REQ_SETPOINT, cmd[15:8], cmd[7:0],
                   SAMPLE_BITS'($urandom), 1'b0, '0);
      end else if (pick < 33) begin
         send_item(ippc_pkg::REQ_SETPOINT, 8'($urandom), 8'($urandom),
                   SAMPLE_BITS'($urandom), 1'b0, '0);
      end else if (pick < 63) begin
         offset = int'($urandom_range(0, 2 * cfg_dead_band + 6))
                  - (int'(cfg_dead_band) + 3);
         pres   = SAMPLE_BITS'(int'(ctl_target) + offset);
         send_item(ippc_pkg::REQ_SAMPLE, 8'($urandom), 8'($urandom), pres, 1'b0, '0);
      end else begin
         send_item(ippc_pkg::REQ_SAMPLE, 8'($urandom), 8'($urandom),
                   SAMPLE_BITS'($urandom), 1'b0, '0);
      end
   endtask

   // Drop valid, wait out every expected result and the pipe's tail.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_drive.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ippc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ippc_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_reg(idx, data);
   endtask

   // Load all five registers plus one write past the map, block idle.
   task automatic load_settings(input logic [ippc_pkg::CSR_DATA_W-1:0] gain_now,
                                input logic [ippc_pkg::CSR_DATA_W-1:0] gain_prev,
                                input logic [ippc_pkg::CSR_DATA_W-1:0] dead_band,
                                input logic [ippc_pkg::CSR_DATA_W-1:0] out_high,
                                input logic [ippc_pkg::CSR_DATA_W-1:0] out_low);
      settle_block();
      write_reg(ippc_pkg::CSR_GAIN_NOW,  gain_now);
      write_reg(ippc_pkg::CSR_GAIN_PREV, gain_prev);
      write_reg(ippc_pkg::CSR_DEAD_BAND, dead_band);
      write_reg(ippc_pkg::CSR_OUT_HIGH,  out_high);
      write_reg(ippc_pkg::CSR_OUT_LOW,   out_low);
      write_reg(CSR_UNMAPPED + ippc_pkg::CSR_IDX_W'($urandom_range(0, 2)),
                ippc_pkg::CSR_DATA_W'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Result channel stall: random, quiet stretches, and one long hold-off
   // ------------------------------------------------------------------------
   initial begin : rsp_stall_driver
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checker: compare each accepted drive with the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drive.size() == 0) begin
            report_mismatch($sformatf("unexpected result drive=%0d", rsp_drive));
         end else begin
            if (rsp_drive !== expected_drive[0])
               report_mismatch($sformatf("drive got %0d expected %0d",
                                         rsp_drive, expected_drive[0]));
            void'(expected_drive.pop_front());
         end
      end
   end

   // ------------------------------------------------------------------------
   // Directed table, default registers. Typed rows: first hold after reset
   // clamps to the lower limit (1000), a full-scale sample slams the output
   // to the lower limit, and the recovery overshoots to the upper one (2400).
   // ------------------------------------------------------------------------
   initial begin
      directed_rows = '{
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'd620,  1'b1, 13'd1000},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'd0,    1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'hFFF,  1'b1, 13'd1000},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'd0,    1'b1, 13'd2400},
         '{ippc_pkg::REQ_SETPOINT, 8'h00, 8'h64, 12'd0,    1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'd920,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'd916,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'd915,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'd924,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'd925,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SETPOINT, 8'h00, 8'h65, 12'd0,    1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'd620,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SETPOINT, 8'hFF, 8'hFF, 12'hFFF,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SETPOINT, 8'h01, 8'h00, 12'd0,    1'b0, 13'd0},
         '{ippc_pkg::REQ_SETPOINT, 8'hAA, 8'h55, 12'hAAA,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SETPOINT, 8'h55, 8'hAA, 12'h555,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SETPOINT, 8'h00, 8'h00, 12'd0,    1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'hFF, 8'hFF, 12'hAAA,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'h555,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'hFFF,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'h000,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SETPOINT, 8'h00, 8'h32, 12'd0,    1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'd770,  1'b0, 13'd0},
         '{ippc_pkg::REQ_SAMPLE,   8'h00, 8'h00, 12'h3FF,  1'b0, 13'd0}
      };
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      logic [ippc_pkg::CSR_DATA_W-1:0] lim_a;
      logic [ippc_pkg::CSR_DATA_W-1:0] lim_b;
      // drive every input to a known value from time zero
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = ippc_pkg::REQ_SETPOINT;
      req_cmd_high   = '0;
      req_cmd_low    = '0;
      req_pressure   = '0;
      csr_we         = 1'b0;
      csr_index      = ippc_pkg::CSR_GAIN_NOW;
      csr_wdata      = '0;
      quiet          = 1'b0;
      hold_go        = 1'b0;
      mismatch_count = 0;

      // reset values of the controller copy
      cfg_gain_now    = ippc_pkg::GAIN_NOW_RST;
      cfg_gain_prev   = ippc_pkg::GAIN_PREV_RST;
      cfg_dead_band   = ippc_pkg::DEAD_BAND_RST;
      cfg_out_high    = ippc_pkg::OUT_HIGH_RST;
      cfg_out_low     = ippc_pkg::OUT_LOW_RST;
      ctl_target      = ippc_pkg::TARGET_RST;
      ctl_last_error  = '0;
      ctl_last_output = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table under the reset settings
      foreach (directed_rows[i])
         send_item(directed_rows[i].kind, directed_rows[i].cmd_high,
                   directed_rows[i].cmd_low, directed_rows[i].pressure,
                   directed_rows[i].typed, directed_rows[i].drive);
      repeat (ITEMS_PER_PHASE) random_item();

      // random phases, each under its own register setting
      for (int phase = 1; phase < PHASE_COUNT; phase++) begin
         case (phase)
            1: load_settings(ippc_pkg::CSR_DATA_W'(ippc_pkg::GAIN_NOW_RST),
                             ippc_pkg::CSR_DATA_W'(ippc_pkg::GAIN_PREV_RST), '0,
                             ippc_pkg::OUT_HIGH_RST, ippc_pkg::OUT_LOW_RST);
            2: load_settings(ippc_pkg::CSR_DATA_W'(ippc_pkg::GAIN_NOW_RST),
                             ippc_pkg::CSR_DATA_W'(ippc_pkg::GAIN_PREV_RST),
                             ippc_pkg::CSR_DATA_W'({ippc_pkg::DBAND_W{1'b1}}),
                             ippc_pkg::OUT_HIGH_RST, ippc_pkg::OUT_LOW_RST);
            3: load_settings(ippc_pkg::CSR_DATA_W'(ippc_pkg::GAIN_NOW_RST),
                             ippc_pkg::CSR_DATA_W'(ippc_pkg::GAIN_PREV_RST),
                             ippc_pkg::CSR_DATA_W'(ippc_pkg::DEAD_BAND_RST),
                             31'd100000000, 31'd500000000);
            4: load_settings(ippc_pkg::CSR_DATA_W'(GAIN_MAX),
                             ippc_pkg::CSR_DATA_W'(GAIN_MAX), 31'd1, LIMIT_MAX, '0);
            5: load_settings('0, '0, ippc_pkg::CSR_DATA_W'(ippc_pkg::DEAD_BAND_RST),
                             LIMIT_MAX, LIMIT_MAX);
            6: begin
               lim_a = ippc_pkg::CSR_DATA_W'($urandom);
               lim_b = ippc_pkg::CSR_DATA_W'($urandom);
               load_settings(ippc_pkg::CSR_DATA_W'($urandom_range(0, GAIN_MAX)),
                             ippc_pkg::CSR_DATA_W'($urandom_range(0, GAIN_MAX)),
                             ippc_pkg::CSR_DATA_W'($urandom_range(0, 16)),
                             (lim_a > lim_b) ? lim_a : lim_b,
                             (lim_a > lim_b) ? lim_b : lim_a);
            end
            default: begin
               // raw words: the bits above each field must be dropped
               load_settings(ippc_pkg::CSR_DATA_W'($urandom),
                             ippc_pkg::CSR_DATA_W'($urandom),
                             ippc_pkg::CSR_DATA_W'($urandom),
                             ippc_pkg::CSR_DATA_W'($urandom),
                             ippc_pkg::CSR_DATA_W'($urandom));
            end
         endcase
         // phase 1: stall the result side long enough to back up the input
         if (phase == 1)
            hold_go = 1'b1;
         // phase 2: no idling on either side
         quiet = (phase == 2);
         repeat (ITEMS_PER_PHASE) random_item();
      end
      quiet = 1'b0;

      // drain, then give stray results a chance to show
      settle_block();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
